// ===== src/wpf_pkg.sv =====
// ----------------------------------------------------------------------------
// wpf_pkg: shared types and constants of the waypoint path follower.
// Command codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none
package wpf_pkg;
  localparam int MaxWaypoints = 64;
  localparam int WpIdxW = $clog2(MaxWaypoints);
  localparam int WpCntW = $clog2(MaxWaypoints + 1);

  typedef enum logic [1:0] {
    CMD_PLACE  = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_APPEND = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_TGT, ST_LD_TGT, ST_SQ, ST_SQRT, ST_DECIDE,
    ST_MUL, ST_DIVX, ST_DIVY, ST_APPLY, ST_RD_PREV, ST_LD_PREV,
    ST_LD_NEW, ST_SEG_SQ, ST_SEG_SQRT, ST_SEG_DECIDE, ST_SNAP, ST_OUT
  } state_t;

  // Datapath operations requested by the controller.
  typedef enum logic [3:0] {
    OP_NONE, OP_PLACE, OP_CLEAR, OP_APPEND, OP_STEP, OP_RD_TGT, OP_LD_TGT,
    OP_SQ, OP_SQRT, OP_MUL, OP_DIVX, OP_DIVY, OP_APPLY, OP_RD_PREV,
    OP_LD_PREV, OP_ADVANCE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic snap;      // with OP_ADVANCE: final waypoint reached
    logic seg_zero;  // with OP_APPLY: place on previous waypoint
    logic start;     // first cycle of an iterative op
  } wpf_cmd_t;

  typedef struct packed {
    logic done;       // iterative op finished
    logic empty;      // path length is zero
    logic reached;    // step >= dist
    logic has_next;   // target+1 < path length
    logic len_zero;   // segment length is zero
  } wpf_stat_t;
endpackage
`default_nettype wire

// ===== src/wpf_ctrl.sv =====
// ----------------------------------------------------------------------------
// wpf_ctrl: sequencing state machine of the waypoint path follower.
// Walks each command through the shared datapath, one step per state.
// ----------------------------------------------------------------------------
`default_nettype none
module wpf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_go,
  input  wire wpf_pkg::cmd_t   in_cmd,
  input  wire logic            out_free,
  output logic                 busy,
  output logic                 res_load,
  output wpf_pkg::wpf_cmd_t    cmd,
  input  wire wpf_pkg::wpf_stat_t stat
);
  import wpf_pkg::*;
  state_t state, state_next;
  logic res_pend, res_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '{op: OP_NONE, snap: 1'b0, seg_zero: 1'b0, start: 1'b0};
    res_load = 1'b0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_go) begin
          unique case (in_cmd)
            CMD_PLACE:  begin cmd.op = OP_PLACE;  state_next = ST_OUT; end
            CMD_CLEAR:  begin cmd.op = OP_CLEAR;  state_next = ST_OUT; end
            CMD_APPEND: begin cmd.op = OP_APPEND; state_next = ST_OUT; end
            CMD_TICK:   begin cmd.op = OP_STEP;   state_next = ST_RD_TGT; end
            default:    state_next = ST_OUT;
          endcase
        end
      end
      ST_RD_TGT: begin
        cmd.op = OP_RD_TGT;
        state_next = stat.empty ? ST_OUT : ST_LD_TGT;
      end
      ST_LD_TGT: begin cmd.op = OP_LD_TGT; state_next = ST_SQ; end
      ST_SQ: begin cmd.op = OP_SQ; state_next = ST_SQRT; end
      ST_SQRT: begin
        cmd.op = OP_SQRT;
        cmd.start = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.op = OP_SQRT;
        if (stat.done) begin
          if (!stat.reached) begin
            state_next = ST_MUL;
          end else if (stat.has_next) begin
            state_next = ST_RD_PREV;
          end else begin
            state_next = ST_SNAP;
          end
        end
      end
      ST_MUL: begin cmd.op = OP_MUL; state_next = ST_DIVX; end
      ST_DIVX: begin
        cmd.op = OP_DIVX;
        cmd.start = 1'b1;
        state_next = ST_DIVY;
      end
      ST_DIVY: begin
        cmd.op = OP_DIVX;
        if (stat.done) begin
          cmd.op = OP_DIVY;
          cmd.start = 1'b1;
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.op = OP_DIVY;
        if (stat.done) begin
          cmd.op = OP_APPLY;
          state_next = ST_OUT;
        end
      end
      ST_RD_PREV: begin cmd.op = OP_RD_PREV; state_next = ST_LD_PREV; end
      ST_LD_PREV: begin cmd.op = OP_LD_PREV; state_next = ST_LD_NEW; end
      ST_LD_NEW: begin cmd.op = OP_LD_TGT; state_next = ST_SEG_SQ; end
      ST_SEG_SQ: begin
        cmd.op = OP_ADVANCE;
        state_next = ST_SEG_SQRT;
      end
      ST_SEG_SQRT: begin
        cmd.op = OP_SQRT;
        cmd.start = 1'b1;
        state_next = ST_SEG_DECIDE;
      end
      ST_SEG_DECIDE: begin
        cmd.op = OP_SQRT;
        if (stat.done) begin
          if (stat.len_zero) begin
            cmd.op = OP_APPLY;
            cmd.seg_zero = 1'b1;
            state_next = ST_OUT;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_SNAP: begin
        cmd.op = OP_ADVANCE;
        cmd.snap = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          res_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Tracks that a result load follows every accepted command.
  always_comb res_pend_next = (in_go && state == ST_IDLE) ? 1'b1 :
                              (res_load ? 1'b0 : res_pend);
  always_ff @(posedge clk) begin
    if (rst) begin
      res_pend <= 1'b0;
    end else begin
      res_pend <= res_pend_next;
    end
  end

  a_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !res_pend) else $error("result pending in idle");
  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    (in_go && state == ST_IDLE) |=> (state != ST_IDLE)) else $error("missed go");
  a_load_out: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (state == ST_OUT)) else $error("load outside ST_OUT");
endmodule
`default_nettype wire

// ===== src/wpf_dp.sv =====
// ----------------------------------------------------------------------------
// wpf_dp: datapath of the waypoint path follower.
// Waypoint memory, agent state, squarer, bit-serial root and divider.
// ----------------------------------------------------------------------------
`default_nettype none
module wpf_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire wpf_pkg::wpf_cmd_t cmd,
  output wpf_pkg::wpf_stat_t     stat,
  input  wire logic [15:0]       in_x,
  input  wire logic [15:0]       in_y,
  input  wire logic [15:0]       in_dt,
  input  wire logic [15:0]       speed,
  output logic signed [15:0]     agent_x,
  output logic signed [15:0]     agent_y,
  output logic [wpf_pkg::WpCntW-1:0] path_len,
  output logic [wpf_pkg::WpCntW-1:0] cur_tgt,
  output logic                   ovf
);
  import wpf_pkg::*;

  logic [31:0] mem [MaxWaypoints];
  logic [31:0] rd_data;
  logic [WpIdxW-1:0] rd_addr;
  logic signed [15:0] org_x, org_y;   // origin of the current move
  logic signed [16:0] vx, vy;         // move direction vector
  logic signed [33:0] vx_sq, vy_sq;
  logic [33:0] sq;                    // squared length
  logic [16:0] len;                   // vector length (root)
  logic [16:0] step;
  logic [17:0] amount;                // distance to travel along vector
  logic signed [34:0] px, py;         // amount * v
  // root unit
  logic [33:0] rt_rem;
  logic [17:0] rt_root;
  logic [4:0]  rt_cnt;
  logic        rt_busy;
  logic [19:0] rt_try_rem;
  logic [33:0] rt_sh;
  // divider unit
  logic [34:0] dv_num;
  logic [35:0] dv_rem;
  logic [34:0] dv_q;
  logic [5:0]  dv_cnt;
  logic        dv_busy, dv_neg;
  logic signed [17:0] qx;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_APPEND && path_len < WpCntW'(MaxWaypoints)) begin
      mem[path_len[WpIdxW-1:0]] <= {in_y, in_x};
    end
    rd_data <= mem[rd_addr];
  end

  // While the previous waypoint is taken, the new target is already read.
  always_comb begin
    rd_addr = cur_tgt[WpIdxW-1:0];
    if (cmd.op == OP_LD_PREV) rd_addr = cur_tgt[WpIdxW-1:0] + WpIdxW'(1);
  end

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) return 16'sh7fff;
    if (v < -19'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      agent_x <= '0; agent_y <= '0; path_len <= '0; cur_tgt <= '0;
      ovf <= 1'b0; rt_busy <= 1'b0; dv_busy <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_PLACE: begin
          agent_x <= in_x; agent_y <= in_y; ovf <= 1'b0;
        end
        OP_CLEAR: begin
          path_len <= '0; cur_tgt <= '0; ovf <= 1'b0;
        end
        OP_APPEND: begin
          if (path_len < WpCntW'(MaxWaypoints)) begin
            path_len <= path_len + 1'b1; ovf <= 1'b0;
          end else begin
            ovf <= 1'b1;
          end
        end
        OP_STEP: begin
          ovf <= 1'b0;
          step <= 17'((({16'd0, speed} * {16'd0, in_dt}) + 32'h8000) >> 16);
        end
        OP_LD_TGT: begin
          vx <= 17'(signed'(rd_data[15:0])) - 17'(org_x);
          vy <= 17'(signed'(rd_data[31:16])) - 17'(org_y);
        end
        OP_RD_TGT: begin
          org_x <= agent_x; org_y <= agent_y;
          amount <= {1'b0, step};
        end
        OP_SQ: sq <= $unsigned(vx_sq + vy_sq);
        OP_ADVANCE: begin
          if (cmd.snap) begin
            agent_x <= signed'(rd_data[15:0]);
            agent_y <= signed'(rd_data[31:16]);
            path_len <= '0; cur_tgt <= '0;
          end else begin
            sq <= $unsigned(vx_sq + vy_sq);
            amount <= {1'b0, step} - {1'b0, len};
          end
        end
        OP_SQRT: begin
          if (cmd.start) begin
            rt_rem <= '0; rt_root <= '0; rt_sh <= sq; rt_cnt <= 5'd17;
            rt_busy <= 1'b1;
          end else if (rt_busy) begin
            if (rt_try_rem[19] == 1'b0) begin
              rt_rem <= 34'(rt_try_rem);
              rt_root <= {rt_root[16:0], 1'b1};
            end else begin
              rt_rem <= {rt_rem[31:0], rt_sh[33:32]};
              rt_root <= {rt_root[16:0], 1'b0};
            end
            rt_sh <= {rt_sh[31:0], 2'b00};
            rt_cnt <= rt_cnt - 1'b1;
            if (rt_cnt == 5'd1) begin
              rt_busy <= 1'b0;
            end
          end else begin
            len <= rt_root[16:0];
          end
        end
        OP_RD_PREV: begin
          cur_tgt <= cur_tgt;
        end
        OP_LD_PREV: begin
          org_x <= signed'(rd_data[15:0]);
          org_y <= signed'(rd_data[31:16]);
          cur_tgt <= cur_tgt + 1'b1;
        end
        OP_MUL: begin
          px <= signed'({17'd0, amount}) * 35'(vx);
          py <= signed'({17'd0, amount}) * 35'(vy);
        end
        OP_DIVX, OP_DIVY: begin
          if (cmd.start) begin
            // The x quotient is still in the divider when the y pass starts.
            if (cmd.op == OP_DIVY) begin
              qx <= dv_neg ? -signed'(dv_q[17:0]) : signed'(dv_q[17:0]);
            end
            dv_neg <= (cmd.op == OP_DIVX) ? px[34] : py[34];
            dv_num <= (cmd.op == OP_DIVX) ? (px[34] ? -px : px) + 35'(len >> 1)
                                          : (py[34] ? -py : py) + 35'(len >> 1);
            dv_rem <= '0; dv_q <= '0; dv_cnt <= 6'd35; dv_busy <= 1'b1;
          end else if (dv_busy) begin
            if ({dv_rem[34:0], dv_num[34]} >= {19'd0, len}) begin
              dv_rem <= {dv_rem[34:0], dv_num[34]} - {19'd0, len};
              dv_q <= {dv_q[33:0], 1'b1};
            end else begin
              dv_rem <= {dv_rem[34:0], dv_num[34]};
              dv_q <= {dv_q[33:0], 1'b0};
            end
            dv_num <= {dv_num[33:0], 1'b0};
            dv_cnt <= dv_cnt - 1'b1;
            if (dv_cnt == 6'd1) dv_busy <= 1'b0;
          end
        end
        OP_APPLY: begin
          if (cmd.seg_zero) begin
            agent_x <= org_x; agent_y <= org_y;
          end else begin
            agent_x <= sat16(19'(org_x) + 19'(qx));
            agent_y <= sat16(19'(org_y) +
                             19'(dv_neg ? -signed'(dv_q[17:0]) : signed'(dv_q[17:0])));
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    vx_sq = vx * vx;
    vy_sq = vy * vy;
    rt_try_rem = {rt_rem[17:0], rt_sh[33:32]} - {rt_root[17:0], 2'b01};
  end

  always_comb begin
    stat.done = !rt_busy && !dv_busy;
    stat.empty = (path_len == '0);
    stat.reached = ({1'b0, step} >= {1'b0, rt_root[16:0]});
    stat.has_next = (WpCntW'(cur_tgt + 1'b1) < path_len);
    stat.len_zero = (rt_root[16:0] == '0);
  end

  a_tgt: assert property (@(posedge clk) disable iff (rst)
    (path_len != '0) |-> (cur_tgt < path_len)) else $error("target past end");
  a_len: assert property (@(posedge clk) disable iff (rst)
    path_len <= WpCntW'(MaxWaypoints)) else $error("path overfull");
  a_units: assert property (@(posedge clk) disable iff (rst)
    !(rt_busy && dv_busy)) else $error("units both busy");
endmodule
`default_nettype wire

// ===== src/waypoint_path_follower_top.sv =====
// ----------------------------------------------------------------------------
// waypoint_path_follower_top: constant-speed waypoint path follower.
// Moves a Q12.4 agent along a loaded waypoint list on each time tick.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command beat; m_axis returns one result beat for it.
//   cfg writes agent_speed and is taken only while the block is idle.
//   Place, clear and append go from idle straight to the output state.
//   A tick runs the shared bit-serial root, then the divider once per axis
//   when it stops short of the target; moving onto the next segment adds
//   a second root pass before the divider. An empty path uses neither unit,
//   and the last waypoint or a zero-length segment skips the divider.
//   One command is in flight at a time.
//   The result sits in an output register; while m_axis_tready is low the
//   next command is still accepted and processed, stalling only when its
//   own result is ready. Reset (synchronous, rst) empties the path, puts the
//   agent at the origin and clears the speed; the waypoint memory is not
//   cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module waypoint_path_follower_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // cmd[1:0], point_x[17:2], point_y[33:18], delta_time[49:34], zero pad
  input  wire logic [55:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // pos_x[15:0], pos_y[31:16], path_active[32], target_index[39:33],
  // append_overflow[40], zero pad
  output logic [47:0]      m_axis_tdata
);
  import wpf_pkg::*;
  logic busy, res_load, go, out_free, ovf;
  logic [15:0] speed;
  logic signed [15:0] ax, ay;
  logic [WpCntW-1:0] plen, ctgt;
  wpf_cmd_t cmd;
  wpf_stat_t stat;

  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= '0;
    end else if (cfg_valid && cfg_ready) begin
      speed <= cfg_data;
    end
  end

  assign s_axis_tready = !busy;
  assign go = s_axis_tvalid && !busy;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  wpf_ctrl u_ctrl (
    .clk, .rst, .in_go(go), .in_cmd(cmd_t'(s_axis_tdata[1:0])),
    .out_free, .busy, .res_load, .cmd, .stat
  );

  wpf_dp u_dp (
    .clk, .rst, .cmd, .stat,
    .in_x(s_axis_tdata[17:2]), .in_y(s_axis_tdata[33:18]),
    .in_dt(s_axis_tdata[49:34]), .speed,
    .agent_x(ax), .agent_y(ay), .path_len(plen), .cur_tgt(ctgt), .ovf
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_axis_tdata <= {7'd0, ovf, 7'(ctgt), (plen != '0), ay, ax};
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/tb_waypoint_path_follower_top.sv =====
// ----------------------------------------------------------------------------
// Waypoint path follower testbench
// Streams place, clear, append and tick commands with random gaps on both
// sides, predicts every result beat in a local model and compares each field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_waypoint_path_follower_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wpf_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 200;

  typedef struct packed {
    logic [15:0] delta_time;
    logic [15:0] py;
    logic [15:0] px;
    cmd_t        cmd;
  } command_beat_t;

  typedef struct packed {
    logic        overflow;
    logic [6:0]  tgt;
    logic        active;
    logic [15:0] y;
    logic [15:0] x;
  } result_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  waypoint_path_follower_top uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [31:0] route [MaxWaypoints];
  int unsigned route_len, heading;
  longint pos_x_q, pos_y_q;
  longint unsigned speed_q;

  command_beat_t pending_cmds[$];
  result_beat_t expected_results[$];
  int mismatches, beats_in, beats_out, ticks_seen, overflows_seen, idle_cycles;
  logic sending_cfg = 1'b0;
  logic [15:0] next_speed;

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint unsigned mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint wpx(int unsigned i);
    return longint'($signed(route[i][15:0]));
  endfunction

  function automatic longint wpy(int unsigned i);
    return longint'($signed(route[i][31:16]));
  endfunction

  function automatic longint seg_len(longint vx, longint vy);
    return longint'(root_floor(longint'(vx * vx + vy * vy)));
  endfunction

  task automatic advance_agent(logic [15:0] dt);
    longint stride, to_go, dx, dy, ox, oy, sxl, syl, slen, over;
    if (route_len == 0) return;
    stride = longint'((speed_q * dt + 64'h8000) >> 16);
    dx = wpx(heading) - pos_x_q;
    dy = wpy(heading) - pos_y_q;
    to_go = seg_len(dx, dy);
    if (stride < to_go) begin
      pos_x_q = sat16(pos_x_q + round_div(stride * dx, to_go));
      pos_y_q = sat16(pos_y_q + round_div(stride * dy, to_go));
      return;
    end
    heading++;
    if (heading < route_len) begin
      ox = wpx(heading - 1);
      oy = wpy(heading - 1);
      sxl = wpx(heading) - ox;
      syl = wpy(heading) - oy;
      slen = seg_len(sxl, syl);
      over = stride - to_go;
      if (slen == 0) begin
        pos_x_q = ox;
        pos_y_q = oy;
      end else begin
        pos_x_q = sat16(ox + round_div(over * sxl, slen));
        pos_y_q = sat16(oy + round_div(over * syl, slen));
      end
    end else begin
      pos_x_q = wpx(route_len - 1);
      pos_y_q = wpy(route_len - 1);
      route_len = 0;
      heading = 0;
    end
  endtask

  task automatic predict_result(command_beat_t c);
    result_beat_t r;
    r.overflow = 1'b0;
    case (c.cmd)
      CMD_PLACE: begin
        pos_x_q = longint'($signed(c.px));
        pos_y_q = longint'($signed(c.py));
      end
      CMD_CLEAR: begin
        route_len = 0;
        heading = 0;
      end
      CMD_APPEND: begin
        if (route_len < MaxWaypoints) begin
          route[route_len] = {c.py, c.px};
          route_len++;
        end else begin
          r.overflow = 1'b1;
        end
      end
      default: advance_agent(c.delta_time);
    endcase
    r.x = pos_x_q[15:0];
    r.y = pos_y_q[15:0];
    r.active = route_len != 0;
    r.tgt = heading[6:0];
    expected_results.push_back(r);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Source side.
  int src_gap;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        predict_result(command_beat_t'(s_axis_tdata[49:0]));
        beats_in++;
        if (s_axis_tdata[1:0] == CMD_TICK) ticks_seen++;
      end
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        s_axis_tdata <= {6'd0, pending_cmds.pop_front()};
        s_axis_tvalid <= 1'b1;
        src_gap = gap_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result side, with random backpressure after each accepted beat.
  int sink_gap;
  always @(posedge clk) begin
    result_beat_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_beat_t'(m_axis_tdata[40:0]);
        beats_out++;
        if (got.overflow) overflows_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got !== want || m_axis_tdata[47:41] !== 7'd0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d: expected x=%h y=%h act=%b tgt=%0d ovf=%b, got x=%h y=%h act=%b tgt=%0d ovf=%b",
                beats_out, want.x, want.y, want.active, want.tgt, want.overflow,
                got.x, got.y, got.active, got.tgt, got.overflow);
          end
        end
        sink_gap = gap_len();
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on accepted beats.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (s_axis_tvalid || expected_results.size() != 0 || sending_cfg) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (cfg_valid && cfg_ready) cfg_valid <= 1'b0;
    else if (sending_cfg && !cfg_valid) begin
      cfg_data <= next_speed;
      cfg_valid <= 1'b1;
    end
  end

  function automatic command_beat_t make_cmd(cmd_t c, logic [15:0] x, logic [15:0] y,
                                              logic [15:0] dt);
    command_beat_t b;
    b.cmd = c;
    b.px = x;
    b.py = y;
    b.delta_time = dt;
    return b;
  endfunction

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  // Waits for every queued beat to complete, then writes a new speed.
  task automatic set_speed(logic [15:0] s);
    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    next_speed = s;
    sending_cfg = 1'b1;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    sending_cfg = 1'b0;
    speed_q = s;
    repeat (2) @(posedge clk);
  endtask

  // A short well-formed route with a few ticks following it.
  task automatic queue_route(int span);
    int n;
    logic [15:0] bx, by;
    n = $urandom_range(1, 6);
    bx = 16'($urandom_range(0, 2 * span)) - 16'(span);
    by = 16'($urandom_range(0, 2 * span)) - 16'(span);
    if ($urandom_range(0, 3) == 0) pending_cmds.push_back(make_cmd(CMD_CLEAR, rnd16(), rnd16(), rnd16()));
    if ($urandom_range(0, 2) == 0) pending_cmds.push_back(make_cmd(CMD_PLACE, bx, by, rnd16()));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) != 0) begin
        bx = bx + 16'($urandom_range(0, 2 * span)) - 16'(span);
        by = by + 16'($urandom_range(0, 2 * span)) - 16'(span);
      end
      pending_cmds.push_back(make_cmd(CMD_APPEND, bx, by, rnd16()));
    end
    for (int i = 0; i < $urandom_range(2, 8); i++)
      pending_cmds.push_back(make_cmd(CMD_TICK, rnd16(), rnd16(), rnd16()));
  endtask

  initial begin
    logic [15:0] speeds [5];
    int budget;
    mismatches = 0; beats_in = 0; beats_out = 0; ticks_seen = 0; overflows_seen = 0;
    idle_cycles = 0;
    route_len = 0; heading = 0; pos_x_q = 0; pos_y_q = 0; speed_q = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Tick with zero speed and an empty path, then extreme points.
    pending_cmds.push_back(make_cmd(CMD_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_cmds.push_back(make_cmd(CMD_PLACE, 16'h7FFF, 16'h8000, 16'hFFFF));
    pending_cmds.push_back(make_cmd(CMD_PLACE, 16'h8000, 16'h7FFF, 16'h0000));
    pending_cmds.push_back(make_cmd(CMD_APPEND, 16'h7FFF, 16'h7FFF, 16'h5555));
    pending_cmds.push_back(make_cmd(CMD_APPEND, 16'h7FFF, 16'h7FFF, 16'hAAAA));
    pending_cmds.push_back(make_cmd(CMD_APPEND, 16'h8000, 16'h8000, 16'h0000));
    pending_cmds.push_back(make_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 16'hAAAA, 16'h5555, 16'hFFFF));
    set_speed(16'hFFFF);
    // Far route: big overshoot, a zero-length segment, then the last waypoint.
    pending_cmds.push_back(make_cmd(CMD_PLACE, 16'h0000, 16'h0000, 16'h0000));
    pending_cmds.push_back(make_cmd(CMD_APPEND, 16'h0010, 16'h0000, 16'h0000));
    pending_cmds.push_back(make_cmd(CMD_APPEND, 16'h0010, 16'h0000, 16'h0000));
    pending_cmds.push_back(make_cmd(CMD_APPEND, 16'h7FFF, 16'h8000, 16'h0000));
    pending_cmds.push_back(make_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0001));
    pending_cmds.push_back(make_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h1000));
    pending_cmds.push_back(make_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'hFFFF));
    pending_cmds.push_back(make_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'hFFFF));
    // Fill the store past capacity so appends overflow.
    for (int i = 0; i < MaxWaypoints + 2; i++)
      pending_cmds.push_back(make_cmd(CMD_APPEND, rnd16(), rnd16(), rnd16()));
    pending_cmds.push_back(make_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h8000));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000));

    speeds[0] = 16'h0000; speeds[1] = 16'd1; speeds[2] = 16'd400;
    speeds[3] = 16'd3000; speeds[4] = 16'hFFFF;
    budget = 660;
    for (int phase = 0; phase < 6; phase++) begin
      set_speed(phase < 5 ? speeds[phase] : rnd16());
      while (pending_cmds.size() < budget / 6) begin
        if ($urandom_range(0, 9) < 8) begin
          queue_route(phase == 4 ? 16000 : (phase < 2 ? 8 : 400));
        end else begin
          pending_cmds.push_back(make_cmd(cmd_t'($urandom_range(0, 3)), rnd16(), rnd16(), rnd16()));
        end
      end
    end

    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("Ran %0d command beats (%0d ticks), %0d result beats, %0d dropped appends.",
             beats_in, ticks_seen, beats_out, overflows_seen);
    $display("Speeds covered zero through full scale with near and far routes.");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
